// ===== rtl/core/sortpq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by sortpq_ctrl, sortpq_dp and sorted_priority_queue; no dependencies.
package sortpq_pkg;

	localparam int W_VALUE       = 32;
	localparam int W_COUNT       = 5;
	localparam int W_STATUS      = 2;
	localparam int W_KIND        = 1;
	localparam int W_OUT_DATA    = 40;
	localparam int DEPTH_DEFAULT = 16;

	localparam logic [W_COUNT-1:0] CAPACITY_RESET = 5'd16;

	localparam logic [W_KIND-1:0] KIND_INSERT = 1'b0;
	localparam logic [W_KIND-1:0] KIND_REMOVE = 1'b1;

	localparam logic [W_STATUS-1:0] STATUS_DONE      = 2'd0;
	localparam logic [W_STATUS-1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [W_STATUS-1:0] STATUS_UNDERFLOW = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the accepted request
		logic exec;   // apply the captured request and load the result
	} sortpq_cmd_t;

endpackage

// ===== rtl/core/sortpq_ctrl.sv =====
// Controller for the sorted priority queue: handshake and sequencing.
// Depends on sortpq_pkg; drives commands into sortpq_dp.
module sortpq_ctrl
	import sortpq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output sortpq_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	assign cmd.load = s_tvalid && s_tready;
	// Hold the request until the output register can take its result.
	assign cmd.exec = (state_q == ST_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.exec) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_accept_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_EXEC)
		else $error("accepted request did not move to execute");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.exec))
		else $error("result appeared without an execute");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && !$past(cmd.exec))
		else $error("pending result was overwritten or dropped");

endmodule

// ===== rtl/core/sortpq_dp.sv =====
// Datapath for the sorted priority queue: cell chain, count, capacity, result.
// Depends on sortpq_pkg; commanded by sortpq_ctrl.
module sortpq_dp
	import sortpq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sortpq_cmd_t                cmd,
	input  logic [W_KIND-1:0]          in_kind,
	input  logic signed [W_VALUE-1:0]  in_value,
	input  logic                       cfg_we,
	input  logic [W_COUNT-1:0]         cfg_wdata,
	output logic [W_STATUS-1:0]        out_status,
	output logic signed [W_VALUE-1:0]  out_removed,
	output logic [W_COUNT-1:0]         out_occupancy
);

	// Cell 0 holds the smallest entry; equal values keep arrival order upward.
	logic signed [W_VALUE-1:0] cell_q [DEPTH];
	logic [DEPTH-1:0]          le;
	logic [W_KIND-1:0]         kind_q;
	logic signed [W_VALUE-1:0] value_q;
	logic [W_COUNT-1:0]        count_q;
	logic [W_COUNT-1:0]        capacity_q;
	logic                      full;
	logic                      empty;
	logic                      do_insert;
	logic                      do_remove;

	assign full  = (count_q >= capacity_q) || (32'(count_q) >= DEPTH);
	assign empty = (count_q == '0);
	assign do_insert = cmd.exec && (kind_q == KIND_INSERT) && !full;
	assign do_remove = cmd.exec && (kind_q == KIND_REMOVE) && !empty;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			value_q <= in_value;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign le[i] = (32'(count_q) > i) && (cell_q[i] <= value_q);

		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (!le[i]) begin
					if (i == 0) begin
						cell_q[i] <= value_q;
					end else if (le[(i == 0) ? 0 : i-1]) begin
						cell_q[i] <= value_q;
					end else begin
						cell_q[i] <= cell_q[(i == 0) ? 0 : i-1];
					end
				end
			end else if (do_remove) begin
				cell_q[i] <= cell_q[(i == DEPTH-1) ? i : i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_insert) begin
			count_q <= count_q + 1'b1;
		end else if (do_remove) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (kind_q == KIND_INSERT) begin
				out_status    <= full ? STATUS_OVERFLOW : STATUS_DONE;
				out_removed   <= '0;
				out_occupancy <= full ? count_q : count_q + 1'b1;
			end else begin
				out_status    <= empty ? STATUS_UNDERFLOW : STATUS_DONE;
				out_removed   <= empty ? '0 : cell_q[0];
				out_occupancy <= empty ? count_q : count_q - 1'b1;
			end
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("entry count beyond store depth");

	a_count_moves_on_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(count_q))
		else $error("entry count changed without an execute");

	a_overflow_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && (kind_q == KIND_INSERT) && full |=> $stable(count_q))
		else $error("overflowing insert changed the entry count");

	a_occupancy_matches: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_occupancy == count_q)
		else $error("reported occupancy differs from entry count");

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted priority queue: min-first, oldest first among equals, bounded by capacity and DEPTH.
// Sequencing: an accepted request is captured, then executed and its result registered
// once the output register is free; no new request is accepted until that execute,
// and a stalled output holds execution of the next request.
// Reset: entry count clears to zero and capacity returns to 16; stored values are
// left undefined and need no clearing pass.
module sorted_priority_queue
	import sortpq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [W_VALUE-1:0]    s_tdata,   // [31:0] value
	input  logic [W_KIND-1:0]     s_tuser,   // [0] kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [W_OUT_DATA-1:0] m_tdata,   // [31:0] removed_value, [36:32] occupancy
	output logic [W_STATUS-1:0]   m_tuser,   // [1:0] status
	input  logic                  cfg_we,
	input  logic [W_COUNT-1:0]    cfg_wdata  // [4:0] capacity
);

	sortpq_cmd_t               cmd;
	logic signed [W_VALUE-1:0] removed;
	logic [W_COUNT-1:0]        occupancy;

	sortpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	sortpq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_kind       (s_tuser),
		.in_value      ($signed(s_tdata)),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_status    (m_tuser),
		.out_removed   (removed),
		.out_occupancy (occupancy)
	);

	assign m_tdata = {(W_OUT_DATA - W_VALUE - W_COUNT)'(0), occupancy, removed};

endmodule
